// ===== design/bufd_pkg.sv =====
// ----------------------------------------------------------------------------
// bufd_pkg
// Shared types and codes for the byte unstuffing frame decoder: item
// structs, status and opcode values, register indexes and reset values.
// ----------------------------------------------------------------------------
package bufd_pkg;

	// default capacity limit of the payload store
	localparam int PAYLOAD_MAX_DEF = 256;

	// register reset values
	localparam logic [7:0] SOF_RST = 8'd161;
	localparam logic [7:0] EOF_RST = 8'd162;
	localparam logic [7:0] ESC_RST = 8'd163;
	localparam logic [8:0] MAX_RST = 9'd256;

	// configuration register indexes
	localparam logic [1:0] REG_SOF = 2'd0;
	localparam logic [1:0] REG_EOF = 2'd1;
	localparam logic [1:0] REG_ESC = 2'd2;
	localparam logic [1:0] REG_MAX = 2'd3;

	// input opcodes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;

	typedef struct packed {
		logic       op;
		logic [7:0] byte_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       data_valid;
		logic [7:0] data_out;
		logic [7:0] data_index;
		logic       frame_error;
		logic       frame_done;
		logic [8:0] payload_length;
	} out_item_t;

endpackage

// ===== design/byte_unstuffing_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// byte_unstuffing_frame_decoder
// Hunts for the start byte, unstuffs escaped bytes up to the end byte and
// reports each payload byte with its index, plus error and done flags.
// ----------------------------------------------------------------------------

// The decoder takes one item (a stuffed byte or a restart) per clock while
// in_ready is high and gives exactly one result item for it. Frame state
// is a payload counter and three flags updated in the cycle an item is
// accepted, so the next item can follow at once; results go into a two-entry
// output buffer (result register plus skid register), so in_ready depends
// only on registered state and input keeps flowing into the skid register
// after the output side stalls. Sustained rate is one item per cycle while
// out_ready is high. Configuration writes are always accepted (cfg_ready is
// tied high) and are meant to happen only while the decoder is idle.
module byte_unstuffing_frame_decoder #(
	parameter int PAYLOAD_MAX = bufd_pkg::PAYLOAD_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bufd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bufd_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);
	import bufd_pkg::*;

	// the 9-bit capacity register bounds the count as well as the parameter
	localparam int CAP_LIM = (PAYLOAD_MAX < 511) ? PAYLOAD_MAX : 511;
	localparam int CNT_W   = $clog2(CAP_LIM + 1);

	logic [7:0]       sof_q, eof_q, esc_q;
	logic [8:0]       max_q;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic             escaped_q, escaped_nxt;
	logic             hunting_q, hunting_nxt;
	logic             open_q, open_nxt;
	out_item_t        res;
	out_item_t        main_q, skid_q;
	logic             main_vld_q, skid_vld_q;
	logic             accept;
	logic [8:0]       cnt9, cap9;
	logic             full;
	logic [7:0]       inv;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !skid_vld_q;
	assign cfg_ready = 1'b1;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_q <= SOF_RST;
			eof_q <= EOF_RST;
			esc_q <= ESC_RST;
			max_q <= MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOF: sof_q <= cfg_data[7:0];
				REG_EOF: eof_q <= cfg_data[7:0];
				REG_ESC: esc_q <= cfg_data[7:0];
				REG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capacity in use and full check
	assign cnt9 = 9'(count_q);
	assign cap9 = (max_q > 9'(CAP_LIM)) ? 9'(CAP_LIM) : max_q;
	assign full = cnt9 >= cap9;
	assign inv  = ~in_data.byte_in;

	// frame decode for one item
	always_comb begin
		count_nxt   = count_q;
		escaped_nxt = escaped_q;
		hunting_nxt = hunting_q;
		open_nxt    = open_q;
		res         = '0;
		if (in_data.op == OP_RESTART) begin
			count_nxt   = '0;
			escaped_nxt = 1'b0;
			hunting_nxt = 1'b1;
			open_nxt    = 1'b1;
		end else if (!open_q) begin
			res.status = ST_CLOSED;
		end else if (hunting_q) begin
			count_nxt   = '0;
			escaped_nxt = 1'b0;
			if (in_data.byte_in == sof_q) begin
				hunting_nxt = 1'b0;
			end else begin
				res.frame_error = 1'b1;
			end
		end else if (in_data.byte_in == sof_q) begin
			// start inside a frame: begin a new one
			count_nxt       = '0;
			escaped_nxt     = 1'b0;
			res.frame_error = 1'b1;
		end else if (in_data.byte_in == eof_q) begin
			if (count_q == '0 || escaped_q) begin
				count_nxt       = '0;
				escaped_nxt     = 1'b0;
				hunting_nxt     = 1'b1;
				res.frame_error = 1'b1;
			end else begin
				open_nxt = 1'b0;
			end
		end else if (in_data.byte_in == esc_q) begin
			if (escaped_q) begin
				count_nxt       = '0;
				escaped_nxt     = 1'b0;
				hunting_nxt     = 1'b1;
				res.frame_error = 1'b1;
			end else if (full) begin
				res.status = ST_FULL;
			end else begin
				escaped_nxt = 1'b1;
			end
		end else if (full) begin
			res.status = ST_FULL;
		end else if (!escaped_q) begin
			res.data_valid = 1'b1;
			res.data_out   = in_data.byte_in;
			res.data_index = cnt9[7:0];
			count_nxt      = count_q + 1'b1;
		end else if (inv == sof_q || inv == eof_q || inv == esc_q) begin
			res.data_valid = 1'b1;
			res.data_out   = inv;
			res.data_index = cnt9[7:0];
			escaped_nxt    = 1'b0;
			count_nxt      = count_q + 1'b1;
		end else begin
			// escaped value that is not a marker
			count_nxt       = '0;
			escaped_nxt     = 1'b0;
			hunting_nxt     = 1'b1;
			res.frame_error = 1'b1;
		end
		res.frame_done     = !open_nxt;
		res.payload_length = 9'(count_nxt);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			escaped_q <= 1'b0;
			hunting_q <= 1'b1;
			open_q    <= 1'b1;
		end else if (accept) begin
			count_q   <= count_nxt;
			escaped_q <= escaped_nxt;
			hunting_q <= hunting_nxt;
			open_q    <= open_nxt;
		end
	end

	// output buffer valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_ready || !main_vld_q) begin
			main_vld_q <= skid_vld_q || accept;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (out_ready || !main_vld_q) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (accept) begin
				main_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	// checks
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry held with empty result register");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt9 <= 9'(CAP_LIM))
		else $error("payload count beyond capacity limit");

	a_done_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.payload_length != 9'd0)
		else $error("closed frame with empty payload");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.data_valid |->
			out_data.status == ST_OK && !out_data.frame_error)
		else $error("payload byte emitted with error or stall status");

endmodule
